// File: hw/rtl/ppc_pkg.sv
package ppc_pkg;

   // Field widths.
   localparam int POS_W  = 32;
   localparam int GAIN_W = 24;
   localparam int LIM_W  = 31;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Reset values of the control registers.
   localparam logic [GAIN_W-1:0] GAIN_RST = 24'd32768;
   localparam logic [LIM_W-1:0]  LIMIT_RST = 31'd9830;
   localparam logic [LIM_W-1:0]  TOL_RST = 31'd1311;

   // Square root and divider geometry.
   localparam int SQRT_ROOT_W = 32;
   localparam int DIV_QUO_W   = 31;
   localparam int DIV_DEN_W   = 32;

   // Register map.
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_TARGET_X = 3'd0,
      CSR_TARGET_Y = 3'd1,
      CSR_GAIN     = 3'd2,
      CSR_LIMIT    = 3'd3,
      CSR_TOL      = 3'd4
   } csr_idx_type;

endpackage

// File: hw/rtl/ppc_sqrt.sv
module ppc_sqrt #(
   parameter int ROOT_W = ppc_pkg::SQRT_ROOT_W
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [2*ROOT_W-1:0]   rad_in,
   output logic [ROOT_W-1:0]     root_out
);
   import ppc_pkg::*;

   // One root bit per stage, most significant bit first.
   logic [ROOT_W-1:0]   rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]   root_ff [ROOT_W];
   logic [2*ROOT_W-1:0] rad_ff  [ROOT_W];

   for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
      logic [ROOT_W-1:0]   rem_prev;
      logic [ROOT_W-1:0]   root_prev;
      logic [2*ROOT_W-1:0] rad_prev;
      logic [ROOT_W+1:0]   cur;
      logic [ROOT_W+1:0]   trial;
      logic [ROOT_W+1:0]   diff;
      logic                take;

      if (i == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = rad_in;
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
         assign rad_prev  = rad_ff[i-1];
      end

      // Bring down two radicand bits and try the next root bit.
      always_comb begin
         cur   = {rem_prev, rad_prev[2*ROOT_W-1 -: 2]};
         trial = {root_prev, 2'b01};
         diff  = cur - trial;
         take  = (cur >= trial);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= take ? diff[ROOT_W-1:0] : cur[ROOT_W-1:0];
            root_ff[i] <= {root_prev[ROOT_W-2:0], take};
            rad_ff[i]  <= {rad_prev[2*ROOT_W-3:0], 2'b00};
         end
      end
   end

   assign root_out = root_ff[ROOT_W-1];

endmodule

// File: hw/rtl/ppc_div.sv
module ppc_div #(
   parameter int QUO_W = ppc_pkg::DIV_QUO_W,
   parameter int DEN_W = ppc_pkg::DIV_DEN_W
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [2*QUO_W-1:0]   num_in,
   input  logic [DEN_W-1:0]     den_in,
   output logic [QUO_W-1:0]     quo_out
);
   import ppc_pkg::*;

   // The upper half of the dividend is below the divisor, so the quotient
   // fits in QUO_W bits and is built one bit per stage.
   logic [DEN_W-1:0] rem_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] low_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];

   for (genvar i = 0; i < QUO_W; i++) begin : g_stage
      logic [DEN_W-1:0] rem_prev;
      logic [DEN_W-1:0] den_prev;
      logic [QUO_W-1:0] low_prev;
      logic [QUO_W-1:0] quo_prev;
      logic [DEN_W:0]   cur;
      logic [DEN_W:0]   diff;
      logic             take;

      if (i == 0) begin : g_first
         assign rem_prev = DEN_W'(num_in[2*QUO_W-1:QUO_W]);
         assign den_prev = den_in;
         assign low_prev = num_in[QUO_W-1:0];
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign den_prev = den_ff[i-1];
         assign low_prev = low_ff[i-1];
         assign quo_prev = quo_ff[i-1];
      end

      // Shift in the next dividend bit and subtract when it fits.
      always_comb begin
         cur  = {rem_prev, low_prev[QUO_W-1]};
         diff = cur - {1'b0, den_prev};
         take = (cur >= {1'b0, den_prev});
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= take ? diff[DEN_W-1:0] : cur[DEN_W-1:0];
            den_ff[i] <= den_prev;
            low_ff[i] <= {low_prev[QUO_W-2:0], 1'b0};
            quo_ff[i] <= {quo_prev[QUO_W-2:0], take};
         end
      end
   end

   assign quo_out = quo_ff[QUO_W-1];

endmodule

// File: hw/rtl/planar_position_p_controller.sv
// Planar proportional position controller with a vector speed limit.
// Request channel: req_valid/req_stall carry one measured position
// (req_meas_x, req_meas_y), signed Q16.16. Response channel:
// rsp_valid/rsp_stall carry the commanded velocity and the at-target flag.
// Control registers are written through csr_valid/csr_ready with csr_addr
// and csr_wdata; csr_ready is always high. Write them only while no request
// is in flight.
// Pipeline: a request passes through six arithmetic stages, a 32-stage
// square root (one root bit per stage), a 31-stage divider (one quotient
// bit per stage) and the output register.
// The fully pipelined datapath takes one request per cycle unless stalled.
// When the output register holds a response that the receiver stalls, the
// whole pipeline holds and req_stall is raised; nothing is lost or repeated.
// Reset clears all valid bits and loads the default target, gain, speed
// limit and tolerance.
module planar_position_p_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [ppc_pkg::POS_W-1:0]    req_meas_x,
   input  logic signed [ppc_pkg::POS_W-1:0]    req_meas_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ppc_pkg::POS_W-1:0]    rsp_cmd_vel_x,
   output logic signed [ppc_pkg::POS_W-1:0]    rsp_cmd_vel_y,
   output logic                                rsp_at_target,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ppc_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [ppc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ppc_pkg::*;

   localparam int SQ_LAT   = SQRT_ROOT_W;
   localparam int TAIL_LAT = SQRT_ROOT_W + DIV_QUO_W;

   typedef struct packed {
      logic             near;
      logic             over;
      logic             negx;
      logic             negy;
      logic [LIM_W-1:0] vx;
      logic [LIM_W-1:0] vy;
   } side_type;

   // Control registers.
   logic signed [POS_W-1:0] target_x_ff, target_y_ff;
   logic [GAIN_W-1:0]       gain_ff;
   logic [LIM_W-1:0]        limit_ff, tol_ff;
   logic [2*LIM_W-1:0]      tol_sq_ff, limit_sq_ff;

   logic en;

   // Stage 1: saturated error and its magnitude.
   logic [POS_W:0]   dx_in, dy_in;
   logic [POS_W-1:0] ex_in, ey_in;
   logic             v1_ff, negx1_ff, negy1_ff;
   logic [POS_W-1:0] aex1_ff, aey1_ff;

   // Stage 2: squared error and gain products.
   logic                v2_ff, negx2_ff, negy2_ff;
   logic [2*POS_W-1:0]  sqx2_ff, sqy2_ff;
   logic [GAIN_W+POS_W-1:0] gx2_ff, gy2_ff;

   // Stage 3: tolerance test and raw command magnitude.
   localparam int AX_W = GAIN_W + POS_W - 16;
   logic              v3_ff, negx3_ff, negy3_ff, near3_ff;
   logic [AX_W-1:0]   ax3_ff, ay3_ff;

   // Stage 4: command squares and normalizing shift.
   localparam int HI_W = AX_W - LIM_W;
   logic [HI_W-1:0]   hi_in;
   logic [3:0]        k_in;
   logic [AX_W-1:0]   nxw_in, nyw_in;
   logic              v4_ff, negx4_ff, negy4_ff, near4_ff, big4_ff;
   logic [2*LIM_W-1:0] sqax4_ff, sqay4_ff;
   logic [LIM_W-1:0]  nx4_ff, ny4_ff, vx4_ff, vy4_ff;

   // Stage 5: limit test and squares of the normalized command.
   logic              v5_ff, negx5_ff, negy5_ff, near5_ff, over5_ff;
   logic [2*LIM_W-1:0] nsqx5_ff, nsqy5_ff;
   logic [LIM_W-1:0]  nx5_ff, ny5_ff, vx5_ff, vy5_ff;

   // Stage 6: radicand and scaled numerators.
   logic               v6_ff;
   side_type           side6_ff;
   logic [2*SQRT_ROOT_W-1:0] rad6_ff;
   logic [2*LIM_W-1:0] px6_ff, py6_ff;

   // Delay lines beside the square root and divider.
   logic               vld_dl_ff  [TAIL_LAT];
   side_type           side_dl_ff [TAIL_LAT];
   logic [2*LIM_W-1:0] px_dl_ff   [SQ_LAT];
   logic [2*LIM_W-1:0] py_dl_ff   [SQ_LAT];

   logic [SQRT_ROOT_W-1:0] root;
   logic [DIV_QUO_W-1:0]   qx, qy;

   // Output register.
   side_type         fin;
   logic [LIM_W-1:0] magx_in, magy_in;
   logic             rsp_valid_ff;
   logic [POS_W-1:0] rsp_x_ff, rsp_y_ff;
   logic             rsp_tgt_ff;

   // The pipeline moves unless a finished response is being stalled.
   assign en        = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = ~en;
   assign csr_ready = 1'b1;

   // Control register writes; squared thresholds follow in the next cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         target_x_ff <= '0;
         target_y_ff <= '0;
         gain_ff     <= GAIN_RST;
         limit_ff    <= LIMIT_RST;
         tol_ff      <= TOL_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_addr)
            CSR_TARGET_X: target_x_ff <= csr_wdata[POS_W-1:0];
            CSR_TARGET_Y: target_y_ff <= csr_wdata[POS_W-1:0];
            CSR_GAIN:     gain_ff     <= csr_wdata[GAIN_W-1:0];
            CSR_LIMIT:    limit_ff    <= csr_wdata[LIM_W-1:0];
            CSR_TOL:      tol_ff      <= csr_wdata[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      tol_sq_ff   <= tol_ff * tol_ff;
      limit_sq_ff <= limit_ff * limit_ff;
   end

   // Error with saturation to the signed 32-bit range.
   always_comb begin
      dx_in = {target_x_ff[POS_W-1], target_x_ff} - {req_meas_x[POS_W-1], req_meas_x};
      dy_in = {target_y_ff[POS_W-1], target_y_ff} - {req_meas_y[POS_W-1], req_meas_y};
      if (dx_in[POS_W] != dx_in[POS_W-1]) begin
         ex_in = dx_in[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end else begin
         ex_in = dx_in[POS_W-1:0];
      end
      if (dy_in[POS_W] != dy_in[POS_W-1]) begin
         ey_in = dy_in[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end else begin
         ey_in = dy_in[POS_W-1:0];
      end
   end

   // Normalizing shift: smallest k that brings both magnitudes below 2^31.
   always_comb begin
      hi_in = ax3_ff[AX_W-1:LIM_W] | ay3_ff[AX_W-1:LIM_W];
      k_in  = '0;
      for (int i = 0; i < HI_W; i++) begin
         if (hi_in[i]) begin
            k_in = 4'(i + 1);
         end
      end
      nxw_in = ax3_ff >> k_in;
      nyw_in = ay3_ff >> k_in;
   end

   // Valid bits of the arithmetic stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   // Arithmetic stages 1 to 6.
   always_ff @(posedge clock) begin
      if (en) begin
         negx1_ff <= dx_in[POS_W];
         negy1_ff <= dy_in[POS_W];
         aex1_ff  <= dx_in[POS_W] ? (~ex_in + 1'b1) : ex_in;
         aey1_ff  <= dy_in[POS_W] ? (~ey_in + 1'b1) : ey_in;

         negx2_ff <= negx1_ff;
         negy2_ff <= negy1_ff;
         sqx2_ff  <= aex1_ff * aex1_ff;
         sqy2_ff  <= aey1_ff * aey1_ff;
         gx2_ff   <= gain_ff * aex1_ff;
         gy2_ff   <= gain_ff * aey1_ff;

         negx3_ff <= negx2_ff;
         negy3_ff <= negy2_ff;
         near3_ff <= (sqx2_ff + sqy2_ff) <= {2'b00, tol_sq_ff};
         ax3_ff   <= gx2_ff[GAIN_W+POS_W-1:16];
         ay3_ff   <= gy2_ff[GAIN_W+POS_W-1:16];

         negx4_ff <= negx3_ff;
         negy4_ff <= negy3_ff;
         near4_ff <= near3_ff;
         big4_ff  <= |hi_in;
         sqax4_ff <= ax3_ff[LIM_W-1:0] * ax3_ff[LIM_W-1:0];
         sqay4_ff <= ay3_ff[LIM_W-1:0] * ay3_ff[LIM_W-1:0];
         nx4_ff   <= nxw_in[LIM_W-1:0];
         ny4_ff   <= nyw_in[LIM_W-1:0];
         vx4_ff   <= ax3_ff[LIM_W-1:0];
         vy4_ff   <= ay3_ff[LIM_W-1:0];

         negx5_ff <= negx4_ff;
         negy5_ff <= negy4_ff;
         near5_ff <= near4_ff;
         over5_ff <= big4_ff
                     | (({1'b0, sqax4_ff} + {1'b0, sqay4_ff}) > {1'b0, limit_sq_ff});
         nsqx5_ff <= nx4_ff * nx4_ff;
         nsqy5_ff <= ny4_ff * ny4_ff;
         nx5_ff   <= nx4_ff;
         ny5_ff   <= ny4_ff;
         vx5_ff   <= vx4_ff;
         vy5_ff   <= vy4_ff;

         side6_ff <= '{near: near5_ff, over: over5_ff, negx: negx5_ff,
                       negy: negy5_ff, vx: vx5_ff, vy: vy5_ff};
         rad6_ff  <= (2*SQRT_ROOT_W)'({1'b0, nsqx5_ff} + {1'b0, nsqy5_ff});
         px6_ff   <= nx5_ff * limit_ff;
         py6_ff   <= ny5_ff * limit_ff;
      end
   end

   // Side data and numerators wait beside the square root and divider.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAIL_LAT; i++) begin
            vld_dl_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_dl_ff[0] <= v6_ff;
         for (int i = 1; i < TAIL_LAT; i++) begin
            vld_dl_ff[i] <= vld_dl_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_dl_ff[0] <= side6_ff;
         for (int i = 1; i < TAIL_LAT; i++) begin
            side_dl_ff[i] <= side_dl_ff[i-1];
         end
         px_dl_ff[0] <= px6_ff;
         py_dl_ff[0] <= py6_ff;
         for (int i = 1; i < SQ_LAT; i++) begin
            px_dl_ff[i] <= px_dl_ff[i-1];
            py_dl_ff[i] <= py_dl_ff[i-1];
         end
      end
   end

   ppc_sqrt #(
      .ROOT_W (SQRT_ROOT_W)
   ) u_sqrt (
      .clock    (clock),
      .en       (en),
      .rad_in   (rad6_ff),
      .root_out (root)
   );

   ppc_div #(
      .QUO_W (DIV_QUO_W),
      .DEN_W (DIV_DEN_W)
   ) u_div_x (
      .clock   (clock),
      .en      (en),
      .num_in  (px_dl_ff[SQ_LAT-1]),
      .den_in  (root),
      .quo_out (qx)
   );

   ppc_div #(
      .QUO_W (DIV_QUO_W),
      .DEN_W (DIV_DEN_W)
   ) u_div_y (
      .clock   (clock),
      .en      (en),
      .num_in  (py_dl_ff[SQ_LAT-1]),
      .den_in  (root),
      .quo_out (qy)
   );

   // Pick the command magnitude: zero, rescaled or plain.
   always_comb begin
      fin = side_dl_ff[TAIL_LAT-1];
      priority if (fin.near) begin
         magx_in = '0;
         magy_in = '0;
      end else if (fin.over) begin
         magx_in = qx;
         magy_in = qy;
      end else begin
         magx_in = fin.vx;
         magy_in = fin.vy;
      end
   end

   // Output register with the sign restored.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld_dl_ff[TAIL_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_x_ff   <= fin.negx ? (~{1'b0, magx_in} + 1'b1) : {1'b0, magx_in};
         rsp_y_ff   <= fin.negy ? (~{1'b0, magy_in} + 1'b1) : {1'b0, magy_in};
         rsp_tgt_ff <= fin.near;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cmd_vel_x = rsp_x_ff;
   assign rsp_cmd_vel_y = rsp_y_ff;
   assign rsp_at_target = rsp_tgt_ff;

   // A response at the target commands no motion.
   a_target_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_at_target |-> rsp_cmd_vel_x == '0 && rsp_cmd_vel_y == '0)
      else $error("velocity not zero at target");

   // A rescaled component never exceeds the speed limit.
   a_rescale_bound: assert property (@(posedge clock) disable iff (reset)
      vld_dl_ff[TAIL_LAT-1] && fin.over && !fin.near |-> qx <= limit_ff && qy <= limit_ff)
      else $error("rescaled command above speed limit");

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

// File: tb/sv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ppc_pkg::*;

   localparam int LATENCY = 69;
   localparam int N_RANDOM = 1250;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic               at_target;
   } velocity_cmd_type;

   // Scoreboard holding the commands that the controller is expected to produce.
   class velocity_scoreboard;
      velocity_cmd_type pending[$];
      int mismatches = 0;
      int checked = 0;

      function void note_request(velocity_cmd_type c);
         pending.push_back(c);
      endfunction

      function void check_response(velocity_cmd_type got);
         velocity_cmd_type exp_cmd;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected response %h %h %b",
                        got.vel_x, got.vel_y, got.at_target);
            return;
         end
         exp_cmd = pending.pop_front();
         checked++;
         if (got !== exp_cmd) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: response %0d expected x=%h y=%h at=%b got x=%h y=%h at=%b",
                        checked, exp_cmd.vel_x, exp_cmd.vel_y, exp_cmd.at_target,
                        got.vel_x, got.vel_y, got.at_target);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [31:0] req_meas_x = 0;
   logic signed [31:0] req_meas_y = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [31:0] rsp_cmd_vel_x;
   logic signed [31:0] rsp_cmd_vel_y;
   logic rsp_at_target;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_ADDR_W-1:0] csr_addr = 0;
   logic [CSR_DATA_W-1:0] csr_wdata = 0;

   planar_position_p_controller i_dut (.*);

   // Predictor copy of the control registers.
   logic signed [31:0] tgt_x, tgt_y;
   logic [23:0] gain;
   logic [30:0] vlimit, tol;

   velocity_scoreboard sb = new();
   longint cycles = 0;
   bit hold_long = 0;
   bit sender_done = 0;
   int n_reached = 0, n_limited = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Computes the velocity command for one measured position.
   function automatic velocity_cmd_type predict_command(logic signed [31:0] mx,
                                                        logic signed [31:0] my);
      velocity_cmd_type c;
      longint ex, ey;
      logic [63:0] aex, aey, ax, ay, lim, m;
      bit over;
      ex = clamp32(longint'(tgt_x) - longint'(mx));
      ey = clamp32(longint'(tgt_y) - longint'(my));
      aex = ex < 0 ? -ex : ex;
      aey = ey < 0 ? -ey : ey;
      lim = {33'd0, vlimit};
      c = '0;
      if (aex * aex + aey * aey <= {33'd0, tol} * {33'd0, tol}) begin
         c.at_target = 1;
         n_reached++;
         return c;
      end
      ax = ({40'd0, gain} * aex) >> 16;
      ay = ({40'd0, gain} * aey) >> 16;
      if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) over = 1;
      else over = ax * ax + ay * ay > lim * lim;
      if (over) begin
         n_limited++;
         while (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) begin
            ax >>= 1;
            ay >>= 1;
         end
         m = int_sqrt(ax * ax + ay * ay);
         if (m == 0) begin
            ax = 0;
            ay = 0;
         end else begin
            ax = ax * lim / m;
            ay = ay * lim / m;
         end
      end
      c.vel_x = ex < 0 ? -ax[31:0] : ax[31:0];
      c.vel_y = ey < 0 ? -ay[31:0] : ay[31:0];
      return c;
   endfunction

   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Writes one control register and updates the predictor's copy.
   task automatic write_reg(csr_idx_type idx, logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1;
      csr_addr <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_TARGET_X: tgt_x = val;
         CSR_TARGET_Y: tgt_y = val;
         CSR_GAIN:     gain = val[23:0];
         CSR_LIMIT:    vlimit = val[30:0];
         CSR_TOL:      tol = val[30:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic set_config(logic [31:0] tx, logic [31:0] ty, logic [31:0] g,
                             logic [31:0] l, logic [31:0] t);
      write_reg(CSR_TARGET_X, tx);
      write_reg(CSR_TARGET_Y, ty);
      write_reg(CSR_GAIN, g);
      write_reg(CSR_LIMIT, l);
      write_reg(CSR_TOL, t);
   endtask

   // Offers one request, optionally after a random gap, and holds it until accepted.
   task automatic send_request(logic signed [31:0] mx, logic signed [31:0] my,
                               bit gaps);
      int g;
      g = gaps ? random_gap() : 0;
      if (g > 0) begin
         @(negedge clock);
         req_valid <= 0;
         repeat (g - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1;
      req_meas_x <= mx;
      req_meas_y <= my;
      do @(posedge clock); while (req_stall);
      sb.note_request(predict_command(mx, my));
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_pos(int mode);
      case (mode)
         0: return $urandom();
         1: return $urandom_range(0, 4000) - 2000;
         2: return $urandom_range(0, 400000) - 200000;
         default: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
      endcase
   endfunction

   function automatic logic [31:0] rand_gain();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 0;
      if (r == 1) return 24'hff_ffff;
      if (r < 5) return $urandom() & 24'hff_ffff;
      return $urandom_range(1000, 200000);
   endfunction

   function automatic logic [31:0] rand_lim();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 0;
      if (r == 1) return 32'h7fff_ffff;
      if (r < 4) return $urandom() & 32'h7fff_ffff;
      return $urandom_range(1, 200000);
   endfunction

   // Stimulus.
   initial begin
      int k, mode;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      tgt_x = 0;
      tgt_y = 0;
      gain = GAIN_RST;
      vlimit = LIMIT_RST;
      tol = TOL_RST;

      // Directed: defaults, inside tolerance, field extremes.
      send_request(0, 0, 0);
      send_request(1311, 0, 0);
      send_request(1312, 0, 0);
      send_request(927, 927, 0);
      send_request(32'h8000_0000, 32'h7fff_ffff, 0);
      send_request(32'h7fff_ffff, 32'h8000_0000, 0);
      send_request(-100, 50, 0);
      send_request(32'hffff_ffff, 32'h5555_aaaa, 0);
      drain();
      // Saturated errors with extreme target, max gain and limit, zero tolerance.
      set_config(32'h7fff_ffff, 32'h8000_0000, 24'hff_ffff, 32'h7fff_ffff, 0);
      send_request(32'h8000_0000, 32'h7fff_ffff, 0);
      send_request(32'h7fff_ffff, 32'h8000_0000, 0);
      send_request(32'h7fff_ffff, 32'h8000_0000 + 1, 0);
      send_request(0, 0, 0);
      drain();
      // Zero limit and zero gain.
      set_config(0, 0, 24'hff_ffff, 0, 10);
      send_request(1000, -1000, 0);
      send_request(5, 5, 0);
      drain();
      write_reg(CSR_GAIN, 0);
      send_request(1000, -1000, 0);
      send_request(32'h8000_0000, 0, 0);
      drain();
      write_reg(CSR_TOL, 32'h7fff_ffff);
      send_request(32'h8000_0000, 32'h8000_0000, 0);
      send_request(12345, -999, 0);
      drain();

      // Random phases with their own settings.
      for (int phase = 0; phase < 10; phase++) begin
         if (phase == 9) set_config(0, 0, GAIN_RST, LIMIT_RST, TOL_RST);
         else set_config($urandom(), $urandom(), rand_gain(), rand_lim(),
                         $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 3000));
         mode = $urandom_range(0, 3);
         // Long receiver hold while the sender keeps offering.
         if (phase == 3) hold_long = 1;
         for (k = 0; k < N_RANDOM / 10; k++) begin
            if ($urandom_range(0, 5) == 0)
               send_request(rand_pos(0), rand_pos(0), phase != 3);
            else
               send_request(tgt_x + rand_pos(mode % 3), tgt_y + rand_pos(mode % 3),
                            phase != 3);
         end
         drain();
      end
      sender_done = 1;
   end

   // Response side: random stalls and one long hold-off.
   initial begin
      int g;
      forever begin
         @(negedge clock);
         if (hold_long) begin
            rsp_stall <= 1;
            repeat (300) @(negedge clock);
            hold_long = 0;
            rsp_stall <= 0;
         end else begin
            g = random_gap();
            rsp_stall <= (g != 0);
            if (g > 1) repeat (g - 1) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response('{rsp_cmd_vel_x, rsp_cmd_vel_y, rsp_at_target});
   end

   // Final report and timeout.
   initial begin
      bit timed_out;
      timed_out = 0;
      while (!sender_done && !timed_out) begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) timed_out = 1;
      end
      if (timed_out) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         $display("Checked %0d velocity commands; %0d inside tolerance, %0d speed-limited.",
                  sb.checked, n_reached, n_limited);
         if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
         else
            $display("Test completed with failures");
         $finish;
      end
   end
endmodule

// File: filelist.f
hw/rtl/ppc_pkg.sv
hw/rtl/ppc_sqrt.sv
hw/rtl/ppc_div.sv
hw/rtl/planar_position_p_controller.sv
tb/sv/testbench.sv
